// ===== design/fla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants for the frame luma auto exposure block
// Word layout, exposure status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int unsigned LumaW   = 16;
  localparam int unsigned RawW    = 8;
  localparam int unsigned CfgIdxW = 2;

  // Nominal frame size in bytes; the last_in_frame mark alone closes a frame
  localparam int unsigned FrameBytes = 3584;

  localparam logic [RawW-1:0]  InvertMask  = 8'hFF;
  localparam int unsigned      DeltaShift  = 9;
  localparam logic [LumaW-1:0] SumMax      = 16'hFFFF;
  localparam logic [LumaW-1:0] MinReset    = 16'd16;
  localparam logic [LumaW-1:0] MaxReset    = 16'hFFFF;
  localparam logic [LumaW-1:0] TargetReset = 16'd21504;
  localparam logic [LumaW-1:0] ExpoReset   = MaxReset >> 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinExposure = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxExposure = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTargetLuma  = 2'd2;

  typedef enum logic [1:0] {
    ST_IN_RANGE = 2'd0,
    ST_DARK     = 2'd1,
    ST_BRIGHT   = 2'd2
  } fla_status_t;

  typedef struct packed {
    logic [RawW-1:0] raw_byte;
    logic            last_in_frame;
  } fla_word_t;

  typedef struct packed {
    logic [LumaW-1:0] expo_floor;
    logic [LumaW-1:0] expo_ceiling;
    logic [LumaW-1:0] target_luma;
  } fla_cfg_t;

endpackage

// ===== design/frame_luma_auto_exposure.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_luma_auto_exposure: sensor byte inversion and frame auto exposure
// Inverts each sensor byte, sums its pixel luma per frame and updates the
// exposure level at every frame end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one raw sensor word per accept,
//   with in_last_in_frame marking the final byte of a frame.
//   Output channel (out_valid / out_stall): exactly one result word per
//   input word, in order: the inverted byte, the frame end flag, and the
//   exposure value and status after any update.
//   An accepted word sits in the input register, then the accumulate
//   and clamp logic feeds the result register, where out_valid rises.
//   Throughput is one word per cycle while the receiver does not stall;
//   the accumulate and clamp path between the two registers is the
//   only per-word work.
//   When the receiver stalls, the result register holds; the input register
//   takes one more word, then in_stall rises until the result is taken.
//   Reset clears the luma sum, sets exposure to half the maximum reset,
//   status to in range, and loads register reset values.
//   Write cfg_* only while no word is in flight.
// ----------------------------------------------------------------------------
module frame_luma_auto_exposure (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fla_pkg::RawW-1:0]     in_raw_byte,
  input  logic                         in_last_in_frame,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fla_pkg::RawW-1:0]     out_pixel_out,
  output logic                         out_frame_end,
  output logic [fla_pkg::LumaW-1:0]    out_exposure_value,
  output logic [1:0]                   out_exposure_status,
  input  logic                         cfg_we,
  input  logic [fla_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fla_pkg::LumaW-1:0]    cfg_wdata
);
  import fla_pkg::*;

  fla_cfg_t         cfg_r;
  fla_word_t        in_word;
  fla_word_t        s1_word;
  logic             s1_valid;
  logic             s1_adv;
  logic             out_free;
  logic [RawW-1:0]  pixel;
  logic [LumaW-1:0] exposure_nxt;
  fla_status_t      status_nxt;
  logic             out_valid_r;
  logic [RawW-1:0]  pixel_r;
  logic             frame_end_r;
  logic [LumaW-1:0] exposure_r;
  fla_status_t      status_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expo_floor   <= MinReset;
      cfg_r.expo_ceiling <= MaxReset;
      cfg_r.target_luma  <= TargetReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMinExposure: cfg_r.expo_floor   <= cfg_wdata;
        RegMaxExposure: cfg_r.expo_ceiling <= cfg_wdata;
        RegTargetLuma:  cfg_r.target_luma  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_word.raw_byte      = in_raw_byte;
  assign in_word.last_in_frame = in_last_in_frame;
  assign out_free              = !out_valid_r || !out_stall;

  fla_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_free (out_free),
    .s1_valid (s1_valid),
    .s1_adv   (s1_adv),
    .s1_word  (s1_word)
  );

  fla_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_adv),
    .word         (s1_word),
    .cfg          (cfg_r),
    .pixel        (pixel),
    .exposure_nxt (exposure_nxt),
    .status_nxt   (status_nxt)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_r     <= pixel;
      frame_end_r <= s1_word.last_in_frame;
      exposure_r  <= exposure_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_out       = pixel_r;
  assign out_frame_end       = frame_end_r;
  assign out_exposure_value  = exposure_r;
  assign out_exposure_status = status_r;

`ifndef NO_ASSERTIONS
  // A held word must back-pressure the input while the result is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid_r && out_stall) |-> in_stall)
    else $error("input not stalled while both stages are full");

  // Clamped-high frame ends report the maximum exposure
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r && status_r == ST_DARK)
      |-> (exposure_r == cfg_r.expo_ceiling))
    else $error("dark status without max exposure");

  // Clamped-low frame ends report the minimum exposure
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r && status_r == ST_BRIGHT)
      |-> (exposure_r == cfg_r.expo_floor))
    else $error("bright status without min exposure");
`endif

endmodule

// ===== design/fla_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_in_stage: input register
// Captures one sensor word and holds it until the result register is free.
// ----------------------------------------------------------------------------
module fla_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fla_pkg::fla_word_t in_word,
  input  logic               out_free,
  output logic               s1_valid,
  output logic               s1_adv,
  output fla_pkg::fla_word_t s1_word
);
  import fla_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  fla_word_t word_r;

  // Advance into the result register whenever it can take a word
  assign s1_adv   = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign s1_valid = valid_r;
  assign s1_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end else if (s1_adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept; hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_word;
    end
  end

endmodule

// ===== design/fla_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_update: luma accumulation and exposure update
// Holds the frame luma sum, exposure level and last status, and updates
// them once per advanced word; presents the post-update values.
// ----------------------------------------------------------------------------
module fla_update (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  fla_pkg::fla_word_t          word,
  input  fla_pkg::fla_cfg_t           cfg,
  output logic [fla_pkg::RawW-1:0]    pixel,
  output logic [fla_pkg::LumaW-1:0]   exposure_nxt,
  output fla_pkg::fla_status_t        status_nxt
);
  import fla_pkg::*;

  logic [LumaW-1:0]        luma_sum_r;
  logic [LumaW-1:0]        luma_sum_nxt;
  logic [LumaW-1:0]        exposure_r;
  fla_status_t             status_r;
  logic [RawW-1:0]         data;
  logic [3:0]              add;
  logic [LumaW:0]          sum_ext;
  logic [LumaW-1:0]        sat_sum;
  logic signed [LumaW:0]   diff;
  logic signed [LumaW:0]   delta;
  logic signed [LumaW+1:0] next_lvl;
  logic signed [LumaW+1:0] max_ext;
  logic signed [LumaW+1:0] min_ext;

  // Invert and sum the four 2-bit pixels
  always_comb begin
    data    = word.raw_byte ^ InvertMask;
    add     = {2'b00, data[7:6]} + {2'b00, data[5:4]}
            + {2'b00, data[3:2]} + {2'b00, data[1:0]};
    sum_ext = {1'b0, luma_sum_r} + {{(LumaW-3){1'b0}}, add};
    sat_sum = sum_ext[LumaW] ? SumMax : sum_ext[LumaW-1:0];
  end

  assign pixel = data;

  // Floor-shifted error, then clamp with the upper bound tested first
  always_comb begin
    diff     = $signed({1'b0, cfg.target_luma}) - $signed({1'b0, sat_sum});
    delta    = diff >>> DeltaShift;
    next_lvl = $signed({2'b00, exposure_r}) + $signed({delta[LumaW], delta});
    max_ext  = $signed({2'b00, cfg.expo_ceiling});
    min_ext  = $signed({2'b00, cfg.expo_floor});
    exposure_nxt = exposure_r;
    status_nxt   = status_r;
    luma_sum_nxt = sat_sum;
    if (word.last_in_frame) begin
      luma_sum_nxt = '0;
      if (next_lvl > max_ext) begin
        exposure_nxt = cfg.expo_ceiling;
        status_nxt   = ST_DARK;
      end else if (next_lvl < min_ext) begin
        exposure_nxt = cfg.expo_floor;
        status_nxt   = ST_BRIGHT;
      end else begin
        exposure_nxt = next_lvl[LumaW-1:0];
        status_nxt   = ST_IN_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_sum_r <= '0;
      exposure_r <= ExpoReset;
      status_r   <= ST_IN_RANGE;
    end else if (fire) begin
      luma_sum_r <= luma_sum_nxt;
      exposure_r <= exposure_nxt;
      status_r   <= status_nxt;
    end
  end

endmodule
